>>> design/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the BMP pixel-data decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  typedef enum logic [1:0] {
    MODE_RGB565 = 2'd0,
    MODE_RGB24  = 2'd1,
    MODE_ARGB32 = 2'd2
  } bpp_mode_e;

  localparam logic [1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam int unsigned CFG_DW = 11;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // floor(n*255/31) and floor(n*255/63) by scaled reciprocal
  localparam logic [21:0] SCALE5_MUL = 22'd2156535;
  localparam int unsigned SCALE5_SH  = 18;
  localparam logic [22:0] SCALE6_MUL = 23'd4244475;
  localparam int unsigned SCALE6_SH  = 20;

  typedef struct packed {
    logic [23:0] pend;
    logic [7:0]  lastb;
    bpp_mode_e   mode;
    logic [9:0]  x;
    logic [9:0]  row;
    logic        last;
  } pix_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'(SCALE5_MUL);
    return p[SCALE5_SH +: 8];
  endfunction

  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(SCALE6_MUL);
    return p[SCALE6_SH +: 8];
  endfunction

endpackage

>>> design/bmp_pixel_stream_to_argb_top.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_to_argb_top
// BMP pixel-data byte stream to 32-bit colour words with column and row.
//
//   channel  direction  handshake              payload
//   in       in         in_valid_i/in_stall_o  data_byte_i
//   out      out        out_valid_o/out_stall_i pixel_color_o pixel_x_o
//                                              pixel_row_o last_pixel_o
//   cfg      in         cfg_we_i               cfg_idx_i cfg_data_i
//
// One byte per cycle is taken while in_stall_o is low. A pixel's last
// byte writes it into the two-entry queue, and the converter then loads
// it into the output register. in_stall_o rises only while the queue is
// full, which happens only after the output has been stalled. Reset is
// asynchronous and leaves the block ready at once; no clearing pass.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_to_argb_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [bmpd_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 pixel_color_o,
  output logic [9:0]                  pixel_x_o,
  output logic [9:0]                  pixel_row_o,
  output logic                        last_pixel_o
);
  import bmpd_pkg::*;

  logic       acc, push, pop, front_done;
  pix_entry_t wr_entry, rd_entry;
  q_status_t  qstat;

  assign in_stall_o = qstat.full;
  assign acc        = in_valid_i && !in_stall_o;

  bmpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (wr_entry),
    .done_o      (front_done)
  );

  bmpd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wr_i   (wr_entry),
    .pop_i  (pop),
    .rd_o   (rd_entry),
    .stat_o (qstat)
  );

  bmpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_i          (rd_entry),
    .stat_i        (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_row_o   (pixel_row_o),
    .last_pixel_o  (last_pixel_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("pixel pushed into full queue");

  a_last_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && wr_entry.last |=> front_done)
    else $error("final pixel did not end the image");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_done |-> !push)
    else $error("pixel emitted after end of image");

endmodule

>>> design/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front
// Configuration registers, row/pixel counters and byte gathering.
// ----------------------------------------------------------------------------
module bmpd_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [bmpd_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                      acc_i,
  input  logic [7:0]                data_byte_i,
  output logic                      push_o,
  output bmpd_pkg::pix_entry_t      entry_o,
  output logic                      done_o
);
  import bmpd_pkg::*;

  localparam int unsigned CCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SRW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BW  = $clog2(4 * MAX_WIDTH + 1) + 1;

  logic [1:0]        mode_q;
  logic [CFG_DW-1:0] width_q, height_q;

  logic [BW-1:0]  bir_q, bir_d;
  logic [1:0]     bip_q, bip_d;
  logic [23:0]    pend_q, pend_d;
  logic [CCW-1:0] col_q, col_d;
  logic [SRW-1:0] src_q, src_d;
  logic           done_q, done_d;

  bpp_mode_e      mode_eff;
  logic [2:0]     bpp;
  logic [CCW-1:0] w;
  logic [SRW-1:0] h;
  logic [BW-1:0]  wx, prod, row_len;
  logic           last;
  logic [SRW-1:0] row_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'(MODE_ARGB32);
      width_q  <= CFG_DW'(1);
      height_q <= CFG_DW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_eff = (mode_q >= 2'd2) ? MODE_ARGB32 : bpp_mode_e'(mode_q);
    bpp      = 3'(mode_eff) + 3'd2;

    if (width_q == '0) w = CCW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) w = CCW'(MAX_WIDTH);
    else w = CCW'(width_q);

    if (height_q == '0) h = SRW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h = SRW'(MAX_HEIGHT);
    else h = SRW'(height_q);

    wx = BW'(w);
    unique case (mode_eff)
      MODE_RGB565: prod = wx << 1;
      MODE_RGB24:  prod = wx + (wx << 1);
      default:     prod = wx << 2;
    endcase
    row_len = (prod + BW'(3)) & ~BW'(3);

    last    = ((CCW + 1)'(col_q) + 1'b1 >= (CCW + 1)'(w)) &&
              ((SRW + 1)'(src_q) + 1'b1 >= (SRW + 1)'(h));
    row_idx = h - SRW'(1) - src_q;
  end

  always_comb begin
    bir_d  = bir_q;
    bip_d  = bip_q;
    pend_d = pend_q;
    col_d  = col_q;
    src_d  = src_q;
    done_d = done_q;
    push_o = 1'b0;

    if (acc_i) begin
      if (done_q || src_q >= h) begin
        done_d = 1'b1;
      end else begin
        if (col_q < w) begin
          if (3'(bip_q) + 3'd1 >= bpp) begin
            push_o = 1'b1;
            col_d  = col_q + CCW'(1);
            bip_d  = 2'd0;
            pend_d = '0;
            if (last) done_d = 1'b1;
          end else begin
            unique case (bip_q)
              2'd0:    pend_d[7:0]   = data_byte_i;
              2'd1:    pend_d[15:8]  = data_byte_i;
              2'd2:    pend_d[23:16] = data_byte_i;
              default: ;
            endcase
            bip_d = bip_q + 2'd1;
          end
        end
        if (bir_q != '1) bir_d = bir_q + BW'(1);
        if (!done_d && col_d >= w && bir_d >= row_len) begin
          bir_d  = '0;
          col_d  = '0;
          bip_d  = 2'd0;
          pend_d = '0;
          src_d  = src_q + SRW'(1);
          if (src_d >= h) done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q  <= '0;
      bip_q  <= '0;
      pend_q <= '0;
      col_q  <= '0;
      src_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bir_q  <= bir_d;
      bip_q  <= bip_d;
      pend_q <= pend_d;
      col_q  <= col_d;
      src_q  <= src_d;
      done_q <= done_d;
    end
  end

  logic [31:0] col_ext, row_ext;
  assign col_ext = 32'(col_q);
  assign row_ext = 32'(row_idx);

  assign entry_o.pend  = pend_q;
  assign entry_o.lastb = data_byte_i;
  assign entry_o.mode  = mode_eff;
  assign entry_o.x     = col_ext[9:0];
  assign entry_o.row   = row_ext[9:0];
  assign entry_o.last  = last;
  assign done_o        = done_q;

endmodule

>>> design/bmpd_fifo.sv
// ----------------------------------------------------------------------------
// bmpd_fifo
// Short queue of gathered pixels between front and back.
// ----------------------------------------------------------------------------
module bmpd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bmpd_pkg::pix_entry_t wr_i,
  input  logic                 pop_i,
  output bmpd_pkg::pix_entry_t rd_o,
  output bmpd_pkg::q_status_t  stat_o
);
  import bmpd_pkg::*;

  pix_entry_t     mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QAW'(1);
      if (pop_i)  rp_q <= rp_q + QAW'(1);
      cnt_q <= cnt_q + (QAW + 1)'(push_i) - (QAW + 1)'(pop_i);
    end
  end

  assign rd_o         = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == (QAW + 1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> design/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back
// Colour conversion and output register.
// ----------------------------------------------------------------------------
module bmpd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmpd_pkg::pix_entry_t rd_i,
  input  bmpd_pkg::q_status_t  stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          pixel_color_o,
  output logic [9:0]           pixel_x_o,
  output logic [9:0]           pixel_row_o,
  output logic                 last_pixel_o
);
  import bmpd_pkg::*;

  logic        valid_q;
  logic [31:0] color_q, color_d;
  logic [9:0]  x_q, row_q;
  logic        last_q;
  logic [15:0] v;
  logic [7:0]  b0, b1, b2;

  always_comb begin
    b0 = rd_i.pend[7:0];
    b1 = rd_i.pend[15:8];
    b2 = rd_i.pend[23:16];
    v  = {rd_i.lastb, b0};
    unique case (rd_i.mode)
      MODE_RGB565: color_d = {ALPHA_OPAQUE, scale5(v[4:0]), scale6(v[10:5]),
                              scale5(v[15:11])};
      MODE_RGB24:  color_d = {ALPHA_OPAQUE, b0, b1, rd_i.lastb};
      default:     color_d = {b0, b1, b2, rd_i.lastb};
    endcase
  end

  assign pop_o = !stat_i.empty && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      color_q <= color_d;
      x_q     <= rd_i.x;
      row_q   <= rd_i.row;
      last_q  <= rd_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign pixel_color_o = color_q;
  assign pixel_x_o     = x_q;
  assign pixel_row_o   = row_q;
  assign last_pixel_o  = last_q;

endmodule

>>> bench/tb_bmp_pixel_stream_to_argb_top.sv
// ----------------------------------------------------------------------------
// tb_bmp_pixel_stream_to_argb_top
// Self-checking bench for the BMP pixel-data byte stream decoder.
//
// Bytes are pushed through the input channel with random gaps, and the output
// channel is stalled at random. An in-bench decoder tracks the row, column
// and pixel counters and predicts every colour word with its column, flipped
// row and last flag. A monitor checks each output transaction against the
// oldest prediction. Directed cases cover all depths, padding, dimension
// clamping and depth/width changes mid-row, followed by random rows under
// changing settings, and the image ends with the last pixel and ignored tail.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_stream_to_argb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpd_pkg::*;

  localparam int unsigned MAX_DIM    = 1024;
  localparam int unsigned SETTLE     = 6;
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned RAND_ITEMS = 500;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] color;
    logic [9:0]  x;
    logic [9:0]  row;
    logic        last;
  } pixel_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [31:0]       pixel_color_o;
  logic [9:0]        pixel_x_o;
  logic [9:0]        pixel_row_o;
  logic              last_pixel_o;

  bmp_pixel_stream_to_argb_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_row_o   (pixel_row_o),
    .last_pixel_o  (last_pixel_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder copy: registers and counters
  logic [1:0]  mode_reg   = MODE_ARGB32;
  logic [10:0] width_reg  = 11'd1;
  logic [10:0] height_reg = 11'd1;
  int unsigned row_bytes  = 0;
  int unsigned pix_bytes  = 0;
  int unsigned pend_bytes = 0;
  int unsigned col        = 0;
  int unsigned src_row    = 0;
  bit          img_done   = 1'b0;

  pixel_t      expected_pixels[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("bmp_pixel_stream_to_argb_top test failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic int unsigned fit_dim(input logic [10:0] v);
    if (v == 0) return 1;
    if (32'(v) > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [31:0] to_argb(input bpp_mode_e md, input logic [23:0] pend,
                                         input logic [7:0] b);
    logic [15:0] v;
    int unsigned r, g, bl;
    v  = {b, pend[7:0]};
    r  = 32'(v[4:0]);
    g  = 32'(v[10:5]);
    bl = 32'(v[15:11]);
    r  = (r * 255) / 31;
    g  = (g * 255) / 63;
    bl = (bl * 255) / 31;
    case (md)
      MODE_RGB565: begin
        return {ALPHA_OPAQUE, r[7:0], g[7:0], bl[7:0]};
      end
      MODE_RGB24: begin
        return {ALPHA_OPAQUE, pend[7:0], pend[15:8], b};
      end
      default: begin
        return {pend[7:0], pend[15:8], pend[23:16], b};
      end
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    bpp_mode_e   md;
    int unsigned bpp, w, h, rsz;
    pixel_t      px;
    bit          fin;
    if (mode_reg == MODE_RGB565) begin
      md = MODE_RGB565;
    end else if (mode_reg == MODE_RGB24) begin
      md = MODE_RGB24;
    end else begin
      md = MODE_ARGB32;
    end
    bpp = (md == MODE_RGB565) ? 2 : (md == MODE_RGB24) ? 3 : 4;
    w   = fit_dim(width_reg);
    h   = fit_dim(height_reg);
    rsz = (w * bpp + 3) & ~32'd3;
    if (img_done || src_row >= h) begin
      img_done = 1'b1;
      return;
    end
    if (col < w) begin
      if (pix_bytes + 1 >= bpp) begin
        fin      = (col + 1 >= w) && (src_row + 1 >= h);
        px.color = to_argb(md, pend_bytes[23:0], b);
        px.x     = 10'(col);
        px.row   = 10'(h - 1 - src_row);
        px.last  = fin;
        expected_pixels.push_back(px);
        col++;
        pix_bytes  = 0;
        pend_bytes = 0;
        if (fin) img_done = 1'b1;
      end else begin
        pend_bytes = (pend_bytes | (32'(b) << (8 * (pix_bytes & 3)))) & 32'hFF_FFFF;
        pix_bytes  = (pix_bytes + 1) & 3;
      end
    end
    row_bytes++;
    if (!img_done && col >= w && row_bytes >= rsz) begin
      row_bytes  = 0;
      col        = 0;
      pix_bytes  = 0;
      pend_bytes = 0;
      src_row++;
      if (src_row >= h) img_done = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    bit          ok;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    decode_byte(b);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IDX_MODE:   mode_reg   = data[1:0];
      CFG_IDX_WIDTH:  width_reg  = data;
      CFG_IDX_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel: pixel_color %h pixel_x %0d pixel_row %0d",
             got.color, got.x, got.row);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.color !== want.color) begin
      $error("pixel_color: expected %h, got %h", want.color, got.color);
      mismatches++;
    end
    if (got.x !== want.x) begin
      $error("pixel_x: expected %0d, got %0d", want.x, got.x);
      mismatches++;
    end
    if (got.row !== want.row) begin
      $error("pixel_row: expected %0d, got %0d", want.row, got.row);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last_pixel: expected %0b, got %0b", want.last, got.last);
      mismatches++;
    end
  endtask

  // output side: sample before the edge, stall at random after each taken pixel
  initial begin
    int unsigned hold;
    bit          take;
    pixel_t      got;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      take = out_valid_o && !out_stall_i;
      got  = '{pixel_color_o, pixel_x_o, pixel_row_o, last_pixel_o};
      @(posedge clk_i);
      if (take) begin
        check_pixel(got);
        hold = draw_wait();
      end
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  task automatic test_rgb565_extremes();
    wait_drained();
    cfg_write(CFG_IDX_HEIGHT, 11'd2047);
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_RGB565));
    cfg_write(CFG_IDX_WIDTH, 11'd2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  task automatic test_rgb24_padding();
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_RGB24));
    cfg_write(CFG_IDX_WIDTH, 11'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
  endtask

  task automatic test_argb32_order();
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_ARGB32));
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
  endtask

  task automatic test_unused_mode_zero_width();
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_UNUSED));
    cfg_write(CFG_IDX_WIDTH, 11'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
  endtask

  task automatic test_width_clamp_midrow();
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_RGB24));
    cfg_write(CFG_IDX_WIDTH, 11'd2047);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hC3);
    // narrower width while the row is open: row closes on the next byte
    wait_drained();
    cfg_write(CFG_IDX_WIDTH, 11'd1);
    send_byte(8'h3C);
  endtask

  task automatic test_depth_change_midpixel();
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_ARGB32));
    cfg_write(CFG_IDX_WIDTH, 11'd2);
    send_byte(8'hE7);
    send_byte(8'h18);
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_RGB565));
    send_byte(8'h9B);
    send_byte(8'h64);
    send_byte(8'hD2);
  endtask

  task automatic test_random_rows();
    int unsigned sent, len, bpp, rsz, i;
    logic [1:0]  md;
    logic [10:0] wv, hv;
    sent = 0;
    while (sent < RAND_ITEMS && src_row < 900) begin
      wait_drained();
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: md = MODE_RGB565;
        1: md = MODE_RGB24;
        2: md = MODE_ARGB32;
        default: md = MODE_UNUSED;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: wv = 11'd0;
          1: wv = 11'(MAX_DIM);
          2: wv = 11'd2047;
          default: wv = 11'($urandom_range(13, 2047));
        endcase
      end else begin
        wv = 11'($urandom_range(1, 12));
      end
      case ($urandom_range(0, 3))
        0: hv = 11'($urandom_range(src_row + 8, MAX_DIM));
        1: hv = 11'd2047;
        default: hv = 11'(MAX_DIM);
      endcase
      cfg_write(CFG_IDX_MODE, CFG_DW'(md));
      cfg_write(CFG_IDX_WIDTH, wv);
      cfg_write(CFG_IDX_HEIGHT, hv);
      bpp = (md == MODE_RGB565) ? 2 : (md == MODE_RGB24) ? 3 : 4;
      rsz = (fit_dim(wv) * bpp + 3) & ~32'd3;
      // mostly whole rows; wide rows and some phases are cut short
      if (fit_dim(wv) > 12 || $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 16);
      end else begin
        len = rsz * $urandom_range(1, 3);
      end
      for (i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)));
      end
      sent += len;
    end
    quiet = 1'b0;
  endtask

  task automatic test_last_pixel_and_tail();
    int unsigned guard;
    wait_drained();
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_ARGB32));
    cfg_write(CFG_IDX_WIDTH, 11'd1);
    guard = 0;
    while ((row_bytes != 0 || col != 0 || pix_bytes != 0) && guard < 64) begin
      send_byte(8'($urandom_range(0, 255)));
      guard++;
    end
    wait_drained();
    cfg_write(CFG_IDX_HEIGHT, 11'(src_row + 1));
    cfg_write(CFG_IDX_MODE, CFG_DW'(MODE_RGB565));
    cfg_write(CFG_IDX_WIDTH, 11'd2);
    guard = 0;
    while (!img_done && guard < 64) begin
      send_byte(8'($urandom_range(0, 255)));
      guard++;
    end
    // bytes after the final pixel are dropped
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
    cfg_write(CFG_IDX_HEIGHT, 11'd0);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_IDX_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rgb565_extremes();
    test_rgb24_padding();
    test_argb32_order();
    test_unused_mode_zero_width();
    test_width_clamp_midrow();
    test_depth_change_midpixel();
    test_random_rows();
    test_last_pixel_and_tail();
    wait_drained();
    if (mismatches == 0) begin
      $display("bmp_pixel_stream_to_argb_top test passed");
    end else begin
      $display("bmp_pixel_stream_to_argb_top test failed");
    end
    $finish;
  end

endmodule

>>> bmp_pixel_stream_to_argb_top.f
design/bmpd_pkg.sv
design/bmpd_front.sv
design/bmpd_fifo.sv
design/bmpd_back.sv
design/bmp_pixel_stream_to_argb_top.sv
bench/tb_bmp_pixel_stream_to_argb_top.sv
